@@ rtl/core/gbp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gbp_pkg: shared types and constants of the Gram block product
// Field widths, operation and register codes, the state encoding and the
// control bundle that travels with each column beat through the MAC stages.
// ----------------------------------------------------------------------------
package gbp_pkg;

    localparam int W_VALUE   = 32;
    localparam int W_DOT     = 64;
    localparam int W_ROWCNT  = 11;
    localparam int W_REFCOLS = 5;
    localparam int W_REFIDX  = 4;
    localparam int W_CFG     = 11;
    localparam int W_CFGIDX  = 1;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_STREAM = 1'b1;

    localparam logic [W_CFGIDX-1:0] CFG_ROW_COUNT = 1'b0;
    localparam logic [W_CFGIDX-1:0] CFG_REF_COLS  = 1'b1;

    localparam logic [W_ROWCNT-1:0]  ROW_COUNT_RST = 11'd1024;
    localparam logic [W_REFCOLS-1:0] REF_COLS_RST  = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    // Control that follows one reference column through the pipeline.
    typedef struct packed {
        logic valid;
        logic row_end;
        logic col_end;
    } t_beat_ctl;

endpackage : gbp_pkg
`default_nettype wire

@@ rtl/core/gbp_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gbp_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered and holds its
// value in cycles without a read enable.
// ----------------------------------------------------------------------------
module gbp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule : gbp_ram
`default_nettype wire

@@ rtl/core/gbp_mac.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gbp_mac: multiply stage and saturating accumulate of one column beat
// Registers the Q16.48 product of a reference word and the streamed value
// together with the old accumulator, then forms the saturated sum.
// ----------------------------------------------------------------------------
module gbp_mac import gbp_pkg::*; #(
    parameter int CIW = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_adv,
    input  wire t_beat_ctl            i_ctl,
    input  wire logic [CIW-1:0]       i_col,
    input  wire logic [W_VALUE-1:0]   i_ref_word,
    input  wire logic [W_VALUE-1:0]   i_x,
    input  wire logic [W_DOT-1:0]     i_acc_word,
    input  wire logic                 i_acc_valid,
    output t_beat_ctl                 o_ctl,
    output logic      [CIW-1:0]       o_col,
    output logic      [W_DOT-1:0]     o_sum
);

    localparam logic [W_DOT-1:0] DOT_MAX = {1'b0, {(W_DOT-1){1'b1}}};
    localparam logic [W_DOT-1:0] DOT_MIN = {1'b1, {(W_DOT-1){1'b0}}};

    t_beat_ctl          r_ctl;
    logic [CIW-1:0]     r_col;
    logic signed [W_DOT-1:0] r_prod;
    logic [W_DOT-1:0]   r_acc;
    logic [W_DOT:0]     w_wide;
    logic               w_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_col  <= i_col;
            r_prod <= $signed(i_ref_word) * $signed(i_x);
            // An accumulator not written since the last column end reads as zero.
            r_acc  <= i_acc_valid ? i_acc_word : '0;
        end
    end

    assign w_wide = {r_acc[W_DOT-1], r_acc} + {r_prod[W_DOT-1], r_prod};
    assign w_ovf  = w_wide[W_DOT] != w_wide[W_DOT-1];

    always_comb begin
        if (w_ovf) begin
            o_sum = w_wide[W_DOT] ? DOT_MIN : DOT_MAX;
        end else begin
            o_sum = w_wide[W_DOT-1:0];
        end
    end

    assign o_ctl = r_ctl;
    assign o_col = r_col;

endmodule : gbp_mac
`default_nettype wire

@@ rtl/core/gram_block_product.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gram_block_product: one block row of A-transpose-A in fixed point
// Reference columns are loaded into a RAM, later columns are streamed and
// multiplied against each reference column, one column per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries i_operation and i_value.
//   A load beat writes one reference element (column-major) as it is accepted;
//   loads past the reference columns in use are dropped.
//   A stream beat reads the same row of every reference column from the
//   reference RAM, one column per cycle unless the output stalls, and
//   accumulates into the accumulator RAM. The single read port of the
//   reference RAM serialises the reference columns in use, and each column
//   then passes the RAM read and the MAC stages; the input stays stalled
//   until the last column has been accumulated.
//   On the last row of a streamed column the beat also emits one result per
//   reference column on the output channel (o_out_valid / i_out_stall), in
//   column order, each through the RAM read, the MAC stages and the output
//   register; o_last marks the final one.
//   If the receiver stalls while a result is pending, the MAC pipeline and
//   the input side hold until the output register frees up.
//   Reset (synchronous, active low) sets rows to 1024, reference columns to
//   16, clears the row and load counters and all accumulators. Reference
//   RAM contents are undefined until loaded. The user must write configuration
//   via i_cfg_we / i_cfg_idx / i_cfg_data only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module gram_block_product import gbp_pkg::*; #(
    parameter int ROWS     = 1024,
    parameter int REF_COLS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [W_CFGIDX-1:0]   i_cfg_idx,
    input  wire logic [W_CFG-1:0]      i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_operation,
    input  wire logic [W_VALUE-1:0]    i_value,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic      [W_DOT-1:0]      o_dot_value,
    output logic      [W_REFIDX-1:0]   o_ref_index,
    output logic                       o_last
);

    localparam int RPW  = $clog2(ROWS);
    localparam int RCW  = $clog2(ROWS + 1);
    localparam int RMW  = (RCW > W_ROWCNT) ? RCW : W_ROWCNT;
    localparam int CIW  = (REF_COLS > 1) ? $clog2(REF_COLS) : 1;
    localparam int CCW  = $clog2(REF_COLS + 1);
    localparam int CLW  = (CCW > W_REFCOLS) ? CCW : W_REFCOLS;
    localparam int CMPW = CCW + 1;
    localparam int AW   = $clog2(ROWS * REF_COLS);
    localparam int IXW  = (CIW > W_REFIDX) ? CIW : W_REFIDX;

    t_state               r_state, n_state;
    logic [W_ROWCNT-1:0]  r_row_count;
    logic [W_REFCOLS-1:0] r_ref_cols;
    logic [RPW-1:0]       r_row_pos, n_row_pos;
    logic [CCW-1:0]       r_load_col, n_load_col;
    logic [CIW-1:0]       r_col, n_col;
    logic                 r_issuing, n_issuing;
    logic [W_VALUE-1:0]   r_x;
    logic [RPW-1:0]       r_row;
    logic                 r_row_end;
    t_beat_ctl            r_s1;
    logic [CIW-1:0]       r_s1_col;
    logic                 r_s1_accv;
    logic [REF_COLS-1:0]  r_acc_vld;
    logic                 r_o_valid;
    logic [W_DOT-1:0]     r_o_dot;
    logic [W_REFIDX-1:0]  r_o_idx;
    logic                 r_o_last;

    logic [RCW-1:0]       w_rows_use;
    logic [RMW-1:0]       w_rows_ext;
    logic [CCW-1:0]       w_cols;
    logic [CLW-1:0]       w_cols_ext;
    logic                 w_row_last;
    logic                 w_in_acc;
    logic                 w_load_wr;
    logic                 w_stream;
    logic                 w_stall;
    logic                 w_adv;
    logic                 w_issue;
    logic                 w_issue_end;
    t_beat_ctl            w_issue_ctl;
    logic [AW-1:0]        w_ref_waddr;
    logic [AW-1:0]        w_ref_raddr;
    logic [W_VALUE-1:0]   w_ref_rdata;
    logic [W_DOT-1:0]     w_acc_rdata;
    t_beat_ctl            w_s2_ctl;
    logic [CIW-1:0]       w_s2_col;
    logic [W_DOT-1:0]     w_s2_sum;
    logic                 w_s2_fire;
    logic                 w_push;
    logic                 w_done;
    logic [IXW-1:0]       w_ix;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= ROW_COUNT_RST;
            r_ref_cols  <= REF_COLS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROW_COUNT: r_row_count <= i_cfg_data;
                CFG_REF_COLS:  r_ref_cols  <= i_cfg_data[W_REFCOLS-1:0];
                default: ;
            endcase
        end
    end

    assign w_rows_ext = RMW'(r_row_count);
    assign w_cols_ext = CLW'(r_ref_cols);

    always_comb begin
        if (r_row_count == '0) begin
            w_rows_use = RCW'(1);
        end else if (w_rows_ext > RMW'(ROWS)) begin
            w_rows_use = RCW'(ROWS);
        end else begin
            w_rows_use = RCW'(w_rows_ext);
        end
        if (r_ref_cols == '0) begin
            w_cols = CCW'(1);
        end else if (w_cols_ext > CLW'(REF_COLS)) begin
            w_cols = CCW'(REF_COLS);
        end else begin
            w_cols = CCW'(w_cols_ext);
        end
    end

    assign w_row_last = (RCW'(r_row_pos) + RCW'(1)) >= w_rows_use;

    // ---------------------------------------------------------------- accept
    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_load_wr  = w_in_acc && (i_operation == OP_LOAD) && (r_load_col < w_cols);
    assign w_stream   = w_in_acc && (i_operation == OP_STREAM);

    // ---------------------------------------------------------------- issue
    // The pipeline freezes only when a result must be shown and the output
    // register is still held by the receiver.
    assign w_stall     = w_s2_ctl.valid && w_s2_ctl.row_end && r_o_valid && i_out_stall;
    assign w_adv       = !w_stall;
    assign w_issue     = (r_state == ST_RUN) && r_issuing && w_adv;
    assign w_issue_end = (CMPW'(r_col) + CMPW'(1)) == CMPW'(w_cols);
    assign w_issue_ctl = '{valid: w_issue, row_end: r_row_end, col_end: w_issue_end};

    assign w_ref_waddr = AW'(AW'(r_load_col[CIW-1:0]) * AW'(ROWS)) + AW'(r_row_pos);
    assign w_ref_raddr = AW'(AW'(r_col) * AW'(ROWS)) + AW'(r_row);

    assign w_s2_fire = w_s2_ctl.valid && w_adv;
    assign w_push    = w_s2_fire && w_s2_ctl.row_end;
    assign w_done    = w_s2_fire && w_s2_ctl.col_end;

    always_comb begin
        n_state    = r_state;
        n_row_pos  = r_row_pos;
        n_load_col = r_load_col;
        n_col      = r_col;
        n_issuing  = r_issuing;
        if (w_load_wr || w_stream) begin
            n_row_pos = w_row_last ? '0 : r_row_pos + RPW'(1);
        end
        if (w_load_wr && w_row_last) begin
            n_load_col = r_load_col + CCW'(1);
        end
        unique case (r_state)
            ST_IDLE: begin
                if (w_stream) begin
                    n_state   = ST_RUN;
                    n_col     = '0;
                    n_issuing = 1'b1;
                end
            end
            ST_RUN: begin
                if (w_issue) begin
                    if (w_issue_end) begin
                        n_issuing = 1'b0;
                    end else begin
                        n_col = r_col + CIW'(1);
                    end
                end
                if (w_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_row_pos  <= '0;
            r_load_col <= '0;
            r_col      <= '0;
            r_issuing  <= 1'b0;
            r_s1       <= '0;
        end else begin
            r_state    <= n_state;
            r_row_pos  <= n_row_pos;
            r_load_col <= n_load_col;
            r_col      <= n_col;
            r_issuing  <= n_issuing;
            if (w_adv) begin
                r_s1 <= w_issue_ctl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stream) begin
            r_x       <= i_value;
            r_row     <= r_row_pos;
            r_row_end <= w_row_last;
        end
        if (w_adv) begin
            r_s1_col  <= r_col;
            r_s1_accv <= r_acc_vld[r_col];
        end
    end

    // Clearing all valid bits at a column end zeroes every accumulator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_vld <= '0;
        end else if (w_done && w_s2_ctl.row_end) begin
            r_acc_vld <= '0;
        end else if (w_s2_fire) begin
            r_acc_vld[w_s2_col] <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- stores
    gbp_ram #(
        .WIDTH (W_VALUE),
        .DEPTH (ROWS * REF_COLS),
        .AW    (AW)
    ) u_ref_ram (
        .i_clk   (i_clk),
        .i_we    (w_load_wr),
        .i_waddr (w_ref_waddr),
        .i_wdata (i_value),
        .i_re    (w_issue),
        .i_raddr (w_ref_raddr),
        .o_rdata (w_ref_rdata)
    );

    gbp_ram #(
        .WIDTH (W_DOT),
        .DEPTH (REF_COLS),
        .AW    (CIW)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (w_s2_fire),
        .i_waddr (w_s2_col),
        .i_wdata (w_s2_sum),
        .i_re    (w_issue),
        .i_raddr (r_col),
        .o_rdata (w_acc_rdata)
    );

    gbp_mac #(
        .CIW (CIW)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_ctl       (r_s1),
        .i_col       (r_s1_col),
        .i_ref_word  (w_ref_rdata),
        .i_x         (r_x),
        .i_acc_word  (w_acc_rdata),
        .i_acc_valid (r_s1_accv),
        .o_ctl       (w_s2_ctl),
        .o_col       (w_s2_col),
        .o_sum       (w_s2_sum)
    );

    // ---------------------------------------------------------------- output
    assign w_ix = IXW'(w_s2_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_push) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_o_dot  <= w_s2_sum;
            r_o_idx  <= w_ix[W_REFIDX-1:0];
            r_o_last <= w_s2_ctl.col_end;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_dot_value = r_o_dot;
    assign o_ref_index = r_o_idx;
    assign o_last      = r_o_last;

endmodule : gram_block_product
`default_nettype wire

@@ rtl/core/gbp_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gbp_checker: port-level checks of the Gram block product
// Watches the input and output channels over time; bound to the top level.
// ----------------------------------------------------------------------------
module gbp_checker import gbp_pkg::*; (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_stall,
    input wire logic                i_operation,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire logic [W_DOT-1:0]    o_dot_value,
    input wire logic [W_REFIDX-1:0] o_ref_index,
    input wire logic                o_last
);

    // A stream beat always leaves the input stalled in the following cycle.
    a_stream_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_operation == OP_STREAM) |=> o_in_stall)
        else $error("input not stalled after a stream beat");

    // A load beat completes in the cycle it is accepted.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_operation == OP_LOAD) |=> !o_in_stall)
        else $error("input stalled after a load beat");

    // Results only come from a stream beat at work.
    a_out_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared while the block was idle");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_dot_value)
            && $stable(o_ref_index) && $stable(o_last))
        else $error("stalled result beat changed");

endmodule : gbp_checker

bind gram_block_product gbp_checker u_gbp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_operation (i_operation),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_dot_value (o_dot_value),
    .o_ref_index (o_ref_index),
    .o_last      (o_last)
);
`default_nettype wire

@@ tb/sv/tb_gram_block_product.sv @@
// ----------------------------------------------------------------------------
// tb_gram_block_product: self-checking testbench of the Gram block product
// Loads reference columns, streams later columns and checks every emitted
// dot product, field by field, against a predictor that runs alongside.
// Directed tests cover saturation, register limits and the shared row
// counter. A random phase then mixes settings, idle gaps and stalls.
// ----------------------------------------------------------------------------
module tb_gram_block_product;
    timeunit 1ns;
    timeprecision 1ps;
    import gbp_pkg::*;

    localparam int ROWS           = 1024;
    localparam int REF_COLS       = 16;
    localparam int TALL_ROWS      = 32;
    localparam int SETTLE_CYCLES  = REF_COLS + 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_STREAMS = 80;

    localparam logic [W_VALUE-1:0] VAL_MIN  = 32'h8000_0000;
    localparam logic [W_VALUE-1:0] VAL_MAX  = 32'h7FFF_FFFF;
    localparam logic [W_VALUE-1:0] VAL_ONES = 32'hFFFF_FFFF;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [W_CFGIDX-1:0]  i_cfg_idx   = '0;
    logic [W_CFG-1:0]     i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 i_operation = 1'b0;
    logic [W_VALUE-1:0]   i_value     = '0;
    logic                 i_out_stall = 1'b0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [W_DOT-1:0]     o_dot_value;
    logic [W_REFIDX-1:0]  o_ref_index;
    logic                 o_last;

    gram_block_product #(
        .ROWS     (ROWS),
        .REF_COLS (REF_COLS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_dot_value (o_dot_value),
        .o_ref_index (o_ref_index),
        .o_last      (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    typedef struct packed {
        logic [W_DOT-1:0]    dot;
        logic [W_REFIDX-1:0] col;
        logic                last;
    } t_dot_result;

    t_dot_result dot_expected[$];

    // Predictor state: reference words, which of them were loaded, sums,
    // the shared row counter, the column being filled and both registers.
    logic [W_VALUE-1:0]      ref_words [REF_COLS*ROWS];
    bit                      word_loaded [REF_COLS][ROWS];
    logic signed [W_DOT-1:0] acc_sum [REF_COLS] = '{default: '0};
    int unsigned             row_ptr  = 0;
    int unsigned             fill_col = 0;
    logic [W_ROWCNT-1:0]     cfg_rows = ROW_COUNT_RST;
    logic [W_REFCOLS-1:0]    cfg_cols = REF_COLS_RST;

    int  mismatches   = 0;
    int  stall_left   = 0;
    int  idle_cycles  = 0;
    bit  beat_held    = 1'b0;
    bit  burst_mode   = 1'b0;

    function automatic int unsigned clamp_cols(int unsigned raw);
        if (raw < 1) return 1;
        if (raw > REF_COLS) return REF_COLS;
        return raw;
    endfunction

    function automatic int unsigned rows_used();
        if (cfg_rows < 1) return 1;
        if (cfg_rows > ROWS) return ROWS;
        return cfg_rows;
    endfunction

    function automatic logic signed [W_DOT-1:0] sat_add(logic signed [W_DOT-1:0] a,
                                                        logic signed [W_DOT-1:0] b);
        logic [W_DOT:0] s;
        s = {a[W_DOT-1], a} + {b[W_DOT-1], b};
        if (s[W_DOT] != s[W_DOT-1])
            return s[W_DOT] ? {1'b1, {(W_DOT-1){1'b0}}} : {1'b0, {(W_DOT-1){1'b1}}};
        return s[W_DOT-1:0];
    endfunction

    function automatic bit advance_row();
        if (row_ptr + 1 >= rows_used()) begin
            row_ptr = 0;
            return 1'b1;
        end
        row_ptr++;
        return 1'b0;
    endfunction

    // True when a stream beat at the current row reads only loaded words.
    function automatic bit row_ready(int unsigned cols);
        for (int c = 0; c < cols; c++)
            if (!word_loaded[c][row_ptr]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [W_VALUE-1:0] rand_value();
        logic signed [W_VALUE-1:0] v;
        v = $urandom;
        case ($urandom_range(0, 7))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return VAL_ONES;
            3: return W_VALUE'($urandom_range(0, 1));
            default: return v >>> $urandom_range(0, 24);
        endcase
    endfunction

    task automatic predict_beat(input logic op, input logic [W_VALUE-1:0] val);
        int unsigned cols;
        int unsigned row;
        longint      prod;
        cols = clamp_cols(cfg_cols);
        row  = (row_ptr >= ROWS) ? ROWS - 1 : row_ptr;
        if (op == OP_LOAD) begin
            // Loads past the columns in use leave every state alone.
            if (fill_col >= cols) return;
            ref_words[fill_col*ROWS + row] = val;
            word_loaded[fill_col][row] = 1'b1;
            if (advance_row()) fill_col++;
            return;
        end
        for (int c = 0; c < cols; c++) begin
            prod = longint'($signed(ref_words[c*ROWS + row])) * longint'($signed(val));
            acc_sum[c] = sat_add(acc_sum[c], prod);
        end
        if (advance_row()) begin
            for (int c = 0; c < cols; c++)
                dot_expected.push_back('{dot: acc_sum[c], col: W_REFIDX'(c),
                                         last: (c == cols - 1)});
            for (int c = 0; c < REF_COLS; c++)
                acc_sum[c] = '0;
        end
    endtask

    task automatic release_input();
        if (beat_held) begin
            i_in_valid <= 1'b0;
            beat_held = 1'b0;
        end
    endtask

    task automatic send_beat(input logic op, input logic [W_VALUE-1:0] val);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 7);
        if (gap != 0) release_input();
        repeat (gap) @(posedge i_clk);
        i_operation <= op;
        i_value     <= val;
        i_in_valid  <= 1'b1;
        beat_held = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        predict_beat(op, val);
    endtask

    task automatic wait_drained();
        release_input();
        while (dot_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [W_CFGIDX-1:0] idx, input logic [W_CFG-1:0] data);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ROW_COUNT) cfg_rows = data[W_ROWCNT-1:0];
        else cfg_cols = data[W_REFCOLS-1:0];
    endtask

    // Column 0 is loaded over TALL_ROWS rows so that one-column settings
    // can later use any row count up to that height.
    task automatic test_tall_column();
        write_reg(CFG_REF_COLS, W_CFG'(1));
        write_reg(CFG_ROW_COUNT, W_CFG'(TALL_ROWS));
        for (int r = 0; r < TALL_ROWS; r++)
            send_beat(OP_LOAD, (r < 4) ? VAL_MIN : rand_value());
        for (int r = 0; r < TALL_ROWS; r++)
            send_beat(OP_STREAM, rand_value());
    endtask

    task automatic test_saturation();
        write_reg(CFG_ROW_COUNT, W_CFG'(4));
        write_reg(CFG_REF_COLS, W_CFG'(2));
        repeat (4) send_beat(OP_LOAD, VAL_MAX);
        // Column 1 is now full, so these loads must be dropped.
        send_beat(OP_LOAD, '0);
        send_beat(OP_LOAD, VAL_ONES);
        send_beat(OP_LOAD, rand_value());
        repeat (4) send_beat(OP_STREAM, VAL_MIN);
        send_beat(OP_STREAM, VAL_MAX);
        send_beat(OP_STREAM, VAL_MIN);
        send_beat(OP_STREAM, '0);
        send_beat(OP_STREAM, VAL_ONES);
    endtask

    task automatic test_register_limits();
        write_reg(CFG_ROW_COUNT, W_CFG'(1));
        repeat (2) send_beat(OP_STREAM, rand_value());
        write_reg(CFG_ROW_COUNT, W_CFG'(0));
        write_reg(CFG_REF_COLS, W_CFG'(0));
        repeat (2) send_beat(OP_STREAM, rand_value());
        write_reg(CFG_ROW_COUNT, W_CFG'(2047));
        repeat (5) send_beat(OP_STREAM, rand_value());
        // The row position is already past the new row count here.
        write_reg(CFG_ROW_COUNT, W_CFG'(3));
        send_beat(OP_STREAM, rand_value());
    endtask

    task automatic test_shared_row_counter();
        write_reg(CFG_ROW_COUNT, W_CFG'(4));
        write_reg(CFG_REF_COLS, W_CFG'(3));
        send_beat(OP_LOAD, rand_value());
        send_beat(OP_LOAD, rand_value());
        // Streamed rows move the shared row counter but not the load column, so later loads refill it.
        write_reg(CFG_REF_COLS, W_CFG'(2));
        send_beat(OP_STREAM, rand_value());
        send_beat(OP_STREAM, rand_value());
        write_reg(CFG_REF_COLS, W_CFG'(31));
        while (fill_col < REF_COLS) send_beat(OP_LOAD, rand_value());
        repeat (2) send_beat(OP_STREAM, rand_value());
        write_reg(CFG_REF_COLS, W_CFG'(3));
        repeat (2) send_beat(OP_STREAM, rand_value());
        write_reg(CFG_REF_COLS, W_CFG'(REF_COLS));
        repeat (4) send_beat(OP_STREAM, rand_value());
    endtask

    task automatic pick_settings();
        int unsigned cols_raw;
        int unsigned rows_raw;
        do begin
            case ($urandom_range(0, 5))
                0: cols_raw = 0;
                1: cols_raw = 1;
                2: cols_raw = REF_COLS;
                3: cols_raw = 31;
                default: cols_raw = $urandom_range(0, 31);
            endcase
        end while (!row_ready(clamp_cols(cols_raw)));
        // Columns past the first hold only four loaded rows.
        if (clamp_cols(cols_raw) >= 2) begin
            rows_raw = $urandom_range(0, 4);
        end else begin
            case ($urandom_range(0, 7))
                0: rows_raw = TALL_ROWS;
                1: rows_raw = TALL_ROWS - 1;
                2: rows_raw = $urandom_range(5, TALL_ROWS);
                default: rows_raw = $urandom_range(0, 4);
            endcase
        end
        write_reg(CFG_REF_COLS, W_CFG'(cols_raw));
        write_reg(CFG_ROW_COUNT, W_CFG'(rows_raw));
    endtask

    task automatic test_random_traffic();
        int streams_sent;
        int seg_len;
        streams_sent = 0;
        while (streams_sent < RANDOM_STREAMS) begin
            pick_settings();
            burst_mode = ($urandom_range(0, 3) == 0);
            seg_len = $urandom_range(8, 40);
            for (int i = 0; i < seg_len; i++) begin
                if ($urandom_range(0, 31) == 0) wait_drained();
                if ($urandom_range(0, 9) == 0) begin
                    send_beat(OP_LOAD, rand_value());
                end else if (row_ready(clamp_cols(cfg_cols))) begin
                    send_beat(OP_STREAM, rand_value());
                    streams_sent++;
                end
            end
            burst_mode = 1'b0;
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_tall_column();
        test_saturation();
        test_register_limits();
        test_shared_row_counter();
        test_random_traffic();
        release_input();
        while (dot_expected.size() != 0) @(posedge i_clk);
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && dot_expected.size() == 0)
            $display("tb_gram_block_product: PASS");
        else
            $display("tb_gram_block_product: FAIL");
        $finish;
    end

    // Result side: check each accepted beat, then hold off for a drawn
    // number of cycles before taking the next one.
    always @(posedge i_clk) begin
        t_dot_result want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (dot_expected.size() == 0) begin
                $display("%0t: unexpected result: dot_value %h ref_index %0d last %0b",
                         $time, o_dot_value, o_ref_index, o_last);
                mismatches++;
            end else begin
                want = dot_expected.pop_front();
                if (o_dot_value !== want.dot) begin
                    $display("%0t: dot_value mismatch: expected %h, actual %h",
                             $time, want.dot, o_dot_value);
                    mismatches++;
                end
                if (o_ref_index !== want.col) begin
                    $display("%0t: ref_index mismatch: expected %0d, actual %0d",
                             $time, want.col, o_ref_index);
                    mismatches++;
                end
                if (o_last !== want.last) begin
                    $display("%0t: last mismatch: expected %0b, actual %0b",
                             $time, want.last, o_last);
                    mismatches++;
                end
            end
            stall_left = burst_mode ? 0 : $urandom_range(0, 7);
            if (stall_left != 0) i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            if (stall_left == 0) i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
            idle_cycles = 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_gram_block_product: FAIL");
            $finish;
        end else begin
            idle_cycles++;
        end
    end

endmodule : tb_gram_block_product

@@ sim.f @@
rtl/core/gbp_pkg.sv
rtl/core/gbp_ram.sv
rtl/core/gbp_mac.sv
rtl/core/gram_block_product.sv
rtl/core/gbp_checker.sv
tb/sv/tb_gram_block_product.sv
